FILE: design/picu_pkg.sv
// ----------------------------------------------------------------------------
// picu_pkg
// Types, codes and helpers shared by the interrupt controller modules.
// ----------------------------------------------------------------------------
package picu_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_SAMPLE = 2'd2,
		KIND_ACK    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PHASE_READY = 2'd0,
		PHASE_ICW2  = 2'd1,
		PHASE_ICW3  = 2'd2,
		PHASE_ICW4  = 2'd3
	} phase_t;

	localparam int LEVELS = 8;
	localparam int LVL_W  = 3;

	localparam int ICW1_INIT_POS = 4;
	localparam int ICW1_IC4_POS  = 0;
	localparam int ICW1_SNGL_POS = 1;
	localparam int ICW4_AEOI_POS = 1;
	localparam int OCW_SEL_POS   = 3;
	localparam int OCW2_EOI_POS  = 5;
	localparam int OCW2_SL_POS   = 6;
	localparam int OCW3_RR_POS   = 1;
	localparam int OCW3_RIS_POS  = 0;

	localparam logic [LVL_W-1:0] SPURIOUS_LEVEL = 3'd7;

	typedef struct packed {
		kind_t       kind;
		logic        port_select;
		logic [7:0]  write_data;
		logic [7:0]  request_lines;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        interrupt_pending;
		logic [7:0]  vector;
		logic        vector_valid;
	} result_t;

	typedef struct packed {
		logic             found;
		logic [LVL_W-1:0] level;
	} prio_t;

	function automatic prio_t lowest_set(input logic [LEVELS-1:0] v);
		prio_t r;
		r.found = 1'b0;
		r.level = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.found = 1'b1;
				r.level = LVL_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [LEVELS-1:0] level_bit(input logic [LVL_W-1:0] l);
		return LEVELS'(1) << l;
	endfunction

	// level that an acknowledge would grant, with found clear when none
	function automatic prio_t eligible(input logic [LEVELS-1:0] irr,
			input logic [LEVELS-1:0] imr, input logic [LEVELS-1:0] isr);
		prio_t req;
		prio_t srv;
		prio_t r;
		req = lowest_set(irr & ~imr);
		srv = lowest_set(isr);
		r.level = req.level;
		r.found = req.found && (!srv.found || req.level < srv.level);
		return r;
	endfunction

endpackage

FILE: design/picu_core.sv
// ----------------------------------------------------------------------------
// picu_core
// Controller state registers and the combinational update for one beat.
// ----------------------------------------------------------------------------
module picu_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  picu_pkg::item_t  item,
	output picu_pkg::result_t result
);
	import picu_pkg::*;

	phase_t            phase_q, phase_d;
	logic              needs_icw4_q, needs_icw4_d;
	logic              single_mode_q, single_mode_d;
	logic [4:0]        vector_base_q, vector_base_d;
	logic [7:0]        cascade_word_q, cascade_word_d;
	logic              auto_eoi_q, auto_eoi_d;
	logic [LEVELS-1:0] mask_q, mask_d;
	logic [LEVELS-1:0] irr_q, irr_d;
	logic [LEVELS-1:0] isr_q, isr_d;
	logic              read_isr_q, read_isr_d;
	logic [7:0]        prev_lines_q, prev_lines_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_READY;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needs_icw4_q   <= 1'b0;
			single_mode_q  <= 1'b0;
			vector_base_q  <= '0;
			cascade_word_q <= '0;
			auto_eoi_q     <= 1'b0;
			mask_q         <= '0;
			irr_q          <= '0;
			isr_q          <= '0;
			read_isr_q     <= 1'b0;
			prev_lines_q   <= '0;
		end else if (advance) begin
			needs_icw4_q   <= needs_icw4_d;
			single_mode_q  <= single_mode_d;
			vector_base_q  <= vector_base_d;
			cascade_word_q <= cascade_word_d;
			auto_eoi_q     <= auto_eoi_d;
			mask_q         <= mask_d;
			irr_q          <= irr_d;
			isr_q          <= isr_d;
			read_isr_q     <= read_isr_d;
			prev_lines_q   <= prev_lines_d;
		end
	end

	always_comb begin
		prio_t      grant;
		prio_t      top_isr;
		prio_t      after;
		logic [7:0] d;
		d              = item.write_data;
		grant          = eligible(irr_q, mask_q, isr_q);
		top_isr        = lowest_set(isr_q);
		phase_d        = phase_q;
		needs_icw4_d   = needs_icw4_q;
		single_mode_d  = single_mode_q;
		vector_base_d  = vector_base_q;
		cascade_word_d = cascade_word_q;
		auto_eoi_d     = auto_eoi_q;
		mask_d         = mask_q;
		irr_d          = irr_q;
		isr_d          = isr_q;
		read_isr_d     = read_isr_q;
		prev_lines_d   = prev_lines_q;
		result         = '0;

		case (item.kind)
			KIND_WRITE: begin
				if (item.port_select) begin
					case (phase_q)
						PHASE_ICW2: begin
							vector_base_d = d[7:3];
							if (!single_mode_q) begin
								phase_d = PHASE_ICW3;
							end else begin
								phase_d = needs_icw4_q ? PHASE_ICW4 : PHASE_READY;
							end
						end
						PHASE_ICW3: begin
							cascade_word_d = d;
							phase_d = needs_icw4_q ? PHASE_ICW4 : PHASE_READY;
						end
						PHASE_ICW4: begin
							auto_eoi_d = d[ICW4_AEOI_POS];
							phase_d    = PHASE_READY;
						end
						default: begin
							mask_d = d;
						end
					endcase
				end else if (d[ICW1_INIT_POS]) begin
					needs_icw4_d  = d[ICW1_IC4_POS];
					single_mode_d = d[ICW1_SNGL_POS];
					mask_d        = '0;
					irr_d         = '0;
					isr_d         = '0;
					auto_eoi_d    = 1'b0;
					read_isr_d    = 1'b0;
					phase_d       = PHASE_ICW2;
				end else if (!d[OCW_SEL_POS]) begin
					if (d[OCW2_EOI_POS]) begin
						if (d[OCW2_SL_POS]) begin
							isr_d = isr_q & ~level_bit(d[LVL_W-1:0]);
						end else if (top_isr.found) begin
							isr_d = isr_q & ~level_bit(top_isr.level);
						end
					end
				end else if (d[OCW3_RR_POS]) begin
					read_isr_d = d[OCW3_RIS_POS];
				end
			end
			KIND_READ: begin
				if (item.port_select) begin
					result.read_data = mask_q;
				end else begin
					result.read_data = read_isr_q ? isr_q : irr_q;
				end
			end
			KIND_SAMPLE: begin
				irr_d        = irr_q | (item.request_lines & ~prev_lines_q);
				prev_lines_d = item.request_lines;
			end
			default: begin
				if (grant.found) begin
					irr_d = irr_q & ~level_bit(grant.level);
					if (!auto_eoi_q) begin
						isr_d = isr_q | level_bit(grant.level);
					end
				end
				result.vector       = {vector_base_q,
					grant.found ? grant.level : SPURIOUS_LEVEL};
				result.vector_valid = 1'b1;
			end
		endcase

		after = eligible(irr_d, mask_d, isr_d);
		result.interrupt_pending = after.found;
	end

endmodule

FILE: design/programmable_interrupt_controller_unit.sv
// ----------------------------------------------------------------------------
// programmable_interrupt_controller_unit
// Single 8259-style interrupt controller driven by a beat stream.
// ----------------------------------------------------------------------------
// Every accepted beat (bus write, bus read, request-line sample or interrupt
// acknowledge) yields exactly one result beat. A beat is taken every cycle
// unless the output side stalls; the input register feeds one state update
// through an eight-level priority encoder into the result register, which
// offers the result. The result register parts the two sides, so input
// beats keep flowing while a result waits, until both stages are full.
module programmable_interrupt_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // port_select, write_data[7:0], request_lines[7:0], zeros
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // read_data[7:0], interrupt_pending, vector[7:0], zeros
	output logic        m_tuser   // vector_valid
);
	import picu_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t result;
	logic    m_valid_q;
	result_t result_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind          <= kind_t'(s_tuser);
			item_s1.port_select   <= s_tdata[0];
			item_s1.write_data    <= s_tdata[8:1];
			item_s1.request_lines <= s_tdata[16:9];
		end
	end

	picu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, result_q.vector, result_q.interrupt_pending,
		result_q.read_data};
	assign m_tuser  = result_q.vector_valid;

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled beat lost from input stage");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("processed beat produced no result");

endmodule

FILE: tb/sv/programmable_interrupt_controller_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// programmable_interrupt_controller_unit_test
// Beat-level test of the 8259-style interrupt controller. A directed opening
// walks the initialisation words, EOI forms, register reads, masking and
// spurious acknowledges. Random traffic follows, built mostly from normal
// operation with occasional complete initialisation sequences, with noise and
// broken sequences mixed in. A scoreboard predicts every result beat and
// compares it field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module programmable_interrupt_controller_unit_test;
	import picu_pkg::*;

	localparam int ITEMS       = 1350;
	localparam int CALM_TAIL   = 150;
	localparam int HOLD_AFTER  = 400;
	localparam int LONG_HOLD   = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN       = 8;

	localparam logic [7:0] ICW1_BASE       = 8'h10;
	localparam logic [7:0] ICW1_IC4        = 8'h01;
	localparam logic [7:0] ICW1_SNGL       = 8'h02;
	localparam logic [7:0] ICW4_AEOI       = 8'h02;
	localparam logic [7:0] EOI_NONSPECIFIC = 8'h20;
	localparam logic [7:0] EOI_SPECIFIC    = 8'h60;
	localparam logic [7:0] OCW2_NO_EOI     = 8'h00;
	localparam logic [7:0] OCW3_READ_IRR   = 8'h0A;
	localparam logic [7:0] OCW3_READ_ISR   = 8'h0B;
	localparam logic [7:0] OCW3_NO_READ    = 8'h08;

	class pic_scoreboard;
		phase_t   phase;
		bit       icw4_wanted;
		bit       single;
		bit [4:0] vector_base;
		bit [7:0] cascade;
		bit       auto_eoi;
		bit [7:0] imr;
		bit [7:0] irr;
		bit [7:0] isr;
		bit       isr_selected;
		bit [7:0] last_lines;
		result_t  replies[$];
		int       beats_in;
		int       beats_out;
		int       mismatches;

		function new();
			phase = PHASE_READY;
		endfunction

		function int first_set(bit [7:0] v);
			for (int i = 0; i < 8; i++) begin
				if (v[i])
					return i;
			end
			return 8;
		endfunction

		function int grant_level();
			int req;
			int srv;
			req = first_set(irr & ~imr);
			srv = first_set(isr);
			return (req < srv) ? req : 8;
		endfunction

		function void command_beat(bit [7:0] d);
			int lvl;
			if (d[ICW1_INIT_POS]) begin
				icw4_wanted  = d[ICW1_IC4_POS];
				single       = d[ICW1_SNGL_POS];
				imr          = '0;
				irr          = '0;
				isr          = '0;
				auto_eoi     = 1'b0;
				isr_selected = 1'b0;
				phase        = PHASE_ICW2;
			end else if (!d[OCW_SEL_POS]) begin
				if (d[OCW2_EOI_POS]) begin
					if (d[OCW2_SL_POS]) begin
						isr[d[2:0]] = 1'b0;
					end else begin
						lvl = first_set(isr);
						if (lvl < 8)
							isr[lvl] = 1'b0;
					end
				end
			end else if (d[OCW3_RR_POS]) begin
				isr_selected = d[OCW3_RIS_POS];
			end
		endfunction

		function void data_beat(bit [7:0] d);
			case (phase)
				PHASE_ICW2: begin
					vector_base = d[7:3];
					if (!single)
						phase = PHASE_ICW3;
					else if (icw4_wanted)
						phase = PHASE_ICW4;
					else
						phase = PHASE_READY;
				end
				PHASE_ICW3: begin
					cascade = d;
					phase = icw4_wanted ? PHASE_ICW4 : PHASE_READY;
				end
				PHASE_ICW4: begin
					auto_eoi = d[ICW4_AEOI_POS];
					phase = PHASE_READY;
				end
				default: imr = d;
			endcase
		endfunction

		function void note_beat(item_t it);
			result_t want;
			int      lvl;
			want = '0;
			beats_in++;
			case (it.kind)
				KIND_WRITE: begin
					if (it.port_select)
						data_beat(it.write_data);
					else
						command_beat(it.write_data);
				end
				KIND_READ: begin
					if (it.port_select)
						want.read_data = imr;
					else
						want.read_data = isr_selected ? isr : irr;
				end
				KIND_SAMPLE: begin
					irr |= it.request_lines & ~last_lines;
					last_lines = it.request_lines;
				end
				default: begin
					lvl = grant_level();
					if (lvl < 8) begin
						irr[lvl] = 1'b0;
						if (!auto_eoi)
							isr[lvl] = 1'b1;
					end else begin
						lvl = SPURIOUS_LEVEL;
					end
					want.vector = {vector_base, lvl[2:0]};
					want.vector_valid = 1'b1;
				end
			endcase
			want.interrupt_pending = grant_level() < 8;
			replies.push_back(want);
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: %s expected %h, got %h",
						beats_out, field, want, got);
			end
		endfunction

		function void check_reply(result_t got);
			result_t want;
			beats_out++;
			if (replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing outstanding", beats_out);
				return;
			end
			want = replies.pop_front();
			compare_field("read_data", want.read_data, got.read_data);
			compare_field("interrupt_pending", {7'd0, want.interrupt_pending},
				{7'd0, got.interrupt_pending});
			compare_field("vector", want.vector, got.vector);
			compare_field("vector_valid", {7'd0, want.vector_valid},
				{7'd0, got.vector_valid});
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // port_select, write_data[7:0], request_lines[7:0], zeros
	logic [1:0]  s_tuser;  // kind[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // read_data[7:0], interrupt_pending, vector[7:0], zeros
	logic        m_tuser;  // vector_valid

	bit            calm = 1'b0;
	bit            long_hold_done = 1'b0;
	int            gap_pct = 20;
	int            quiet_cycles = 0;
	pic_scoreboard board = new();

	programmable_interrupt_controller_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	task automatic send_beat(input kind_t kind, input logic port, input logic [7:0] wdata,
			input logic [7:0] lines);
		item_t it;
		it.kind = kind;
		it.port_select = port;
		it.write_data = wdata;
		it.request_lines = lines;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, lines, wdata, port};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		board.note_beat(it);
	endtask

	task automatic send_traffic();
		int         pick;
		logic [7:0] d;
		pick = $urandom_range(0, 99);
		d = 8'($urandom_range(0, 255));
		if (pick < 25) begin
			send_beat(KIND_SAMPLE, 1'($urandom), 8'($urandom), d);
		end else if (pick < 45) begin
			send_beat(KIND_ACK, 1'($urandom), 8'($urandom), d);
		end else if (pick < 58) begin
			case ($urandom_range(0, 2))
				0: d = EOI_NONSPECIFIC;
				1: d = EOI_SPECIFIC | 8'($urandom_range(0, 7));
				default: begin
					d[ICW1_INIT_POS] = 1'b0;
					d[OCW_SEL_POS] = 1'b0;
				end
			endcase
			send_beat(KIND_WRITE, 1'b0, d, 8'($urandom));
		end else if (pick < 72) begin
			send_beat(KIND_READ, 1'($urandom), 8'($urandom), d);
		end else if (pick < 80) begin
			send_beat(KIND_WRITE, 1'b1, d & 8'($urandom), 8'($urandom));
		end else if (pick < 87) begin
			d[ICW1_INIT_POS] = 1'b0;
			d[OCW_SEL_POS] = 1'b1;
			send_beat(KIND_WRITE, 1'b0, d, 8'($urandom));
		end else begin
			send_beat(kind_t'($urandom_range(0, 3)), 1'($urandom), d, 8'($urandom));
		end
	endtask

	// a broken sequence takes a stray beat and may stop short
	task automatic send_init(input bit broken);
		logic [7:0] icw1;
		int         cut;
		icw1 = 8'($urandom);
		icw1[ICW1_INIT_POS] = 1'b1;
		cut = broken ? $urandom_range(1, 3) : 4;
		send_beat(KIND_WRITE, 1'b0, icw1, 8'($urandom));
		if (broken)
			send_traffic();
		if (cut >= 2)
			send_beat(KIND_WRITE, 1'b1, 8'($urandom), 8'($urandom));
		if (cut >= 3 && !icw1[ICW1_SNGL_POS])
			send_beat(KIND_WRITE, 1'b1, 8'($urandom), 8'($urandom));
		if (cut >= 4 && icw1[ICW1_IC4_POS])
			send_beat(KIND_WRITE, 1'b1, 8'($urandom), 8'($urandom));
	endtask

	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_data = m_tdata[7:0];
			got.interrupt_pending = m_tdata[8];
			got.vector = m_tdata[16:9];
			got.vector_valid = m_tuser;
			board.check_reply(got);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// receiver: random stalls, one long hold-off, steady towards the end
	initial begin
		int run_left;
		int stall_left;
		run_left = 0;
		stall_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!long_hold_done && board.beats_in >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
				m_tready <= 1'b1;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				m_tready <= 1'b1;
				run_left--;
			end else if ($urandom_range(0, 2) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				run_left = $urandom_range(1, 40) - 1;
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int iter;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_WRITE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(KIND_READ, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_READ, 1'b1, 8'hFF, 8'hFF);
		send_beat(KIND_ACK, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_SAMPLE, 1'b0, 8'h00, 8'hFF);
		send_beat(KIND_ACK, 1'b1, 8'hFF, 8'h00);
		send_beat(KIND_WRITE, 1'b0, ICW1_BASE | ICW1_IC4, 8'h00);
		send_beat(KIND_SAMPLE, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_SAMPLE, 1'b0, 8'h00, 8'h80);
		// acknowledge mid-initialisation, then a command write that keeps the phase
		send_beat(KIND_ACK, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_WRITE, 1'b0, OCW3_READ_ISR, 8'h00);
		send_beat(KIND_WRITE, 1'b1, 8'hFF, 8'h00);
		send_beat(KIND_WRITE, 1'b1, 8'hA5, 8'h00);
		send_beat(KIND_WRITE, 1'b1, ICW4_AEOI, 8'h00);
		send_beat(KIND_READ, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_WRITE, 1'b0, EOI_NONSPECIFIC, 8'h00);
		send_beat(KIND_WRITE, 1'b1, 8'hFE, 8'h00);
		send_beat(KIND_SAMPLE, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_SAMPLE, 1'b0, 8'h00, 8'hFF);
		send_beat(KIND_ACK, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_WRITE, 1'b0, ICW1_BASE | ICW1_SNGL | ICW1_IC4, 8'h00);
		send_beat(KIND_WRITE, 1'b1, 8'h07, 8'h00);
		send_beat(KIND_WRITE, 1'b1, 8'hFD, 8'h00);
		send_beat(KIND_SAMPLE, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_SAMPLE, 1'b0, 8'h00, 8'h03);
		send_beat(KIND_ACK, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_ACK, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_WRITE, 1'b0, OCW2_NO_EOI, 8'h00);
		send_beat(KIND_WRITE, 1'b0, EOI_SPECIFIC, 8'h00);
		send_beat(KIND_WRITE, 1'b0, OCW3_NO_READ, 8'h00);
		send_beat(KIND_WRITE, 1'b0, OCW3_READ_IRR, 8'h00);
		send_beat(KIND_READ, 1'b0, 8'h00, 8'h00);
		send_beat(KIND_WRITE, 1'b0, ICW1_BASE | ICW1_SNGL, 8'h00);
		send_beat(KIND_WRITE, 1'b1, 8'h00, 8'h00);

		iter = 0;
		while (board.beats_in < ITEMS) begin
			if (iter % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 20;
					default: gap_pct = 50;
				endcase
			end
			calm = (ITEMS - board.beats_in) < CALM_TAIL;
			if ($urandom_range(0, 99) < 3)
				send_init($urandom_range(0, 4) == 0);
			else
				send_traffic();
			iter++;
		end
		s_tvalid <= 1'b0;

		while (board.replies.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (board.mismatches == 0 && board.replies.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: programmable_interrupt_controller_unit.f
design/picu_pkg.sv
design/picu_core.sv
design/programmable_interrupt_controller_unit.sv
tb/sv/programmable_interrupt_controller_unit_test.sv
